// File: hw/rtl/dnv_pkg.sv
package dnv_pkg;

  localparam int unsigned MaxPartLen = 8;
  localparam int unsigned MaxNameLen = 44;
  localparam int unsigned CntW       = 6;
  localparam int unsigned MemLenW    = 4;

  localparam logic [CntW-1:0]    CntMax   = {CntW{1'b1}};
  localparam logic [CntW-1:0]    PartLim  = CntW'(MaxPartLen);
  localparam logic [CntW-1:0]    NameLim  = CntW'(MaxNameLen);
  localparam logic [MemLenW-1:0] MemLenMax = {MemLenW{1'b1}};

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_LPAR   = 8'h28;
  localparam logic [7:0] CH_RPAR   = 8'h29;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_AT     = 8'h40;

  typedef enum logic [2:0] {
    ST_OK,
    ST_EMPTY,
    ST_PART_LONG,
    ST_BAD_CHAR,
    ST_STRUCT,
    ST_NAME_LONG,
    ST_EMPTY_MEMBER
  } status_e;

  typedef enum logic [1:0] {
    PH_QUAL,
    PH_MEMBER
  } phase_e;

  typedef struct packed {
    logic       valid;
    logic [7:0] name_byte;
  } beat_t;

  typedef struct packed {
    status_e             status;
    logic [CntW-1:0]     dataset_length;
    logic [MemLenW-1:0]  member_length;
    logic                has_member;
  } result_t;

  function automatic logic is_letter(input logic [7:0] c);
    return c inside {[8'h41:8'h5A], [8'h61:8'h7A], CH_HASH, CH_AT, CH_DOLLAR};
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
    return (v == CntMax) ? CntMax : v + CntW'(1);
  endfunction

  // error after closing a qualifier; first error sticks
  function automatic status_e seg_check(input status_e err, input logic [CntW-1:0] cnt,
                                        input logic bad);
    status_e r;
    r = err;
    if (err == ST_OK) begin
      if (cnt > PartLim) r = ST_PART_LONG;
      else if (cnt == '0) r = ST_STRUCT;
      else if (bad) r = ST_BAD_CHAR;
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/dnv_in_stage.sv
module dnv_in_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [7:0]    name_byte_i,
  input  logic          adv_i,
  output logic          in_stall_o,
  output dnv_pkg::beat_t beat_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       load;

  assign in_stall_o = valid_q & ~adv_i;
  assign load       = ~in_stall_o;
  assign valid_d    = load ? in_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && in_valid_i) begin
      byte_q <= name_byte_i;
    end
  end

  assign beat_o.valid     = valid_q;
  assign beat_o.name_byte = byte_q;

endmodule

// File: hw/rtl/dnv_scan.sv
module dnv_scan (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dnv_pkg::beat_t   beat_i,
  input  logic             fire_i,
  output dnv_pkg::result_t result_o
);

  localparam int unsigned CntW = dnv_pkg::CntW;

  dnv_pkg::phase_e  phase_q, phase_d;
  logic [CntW-1:0]  seg_cnt_q, seg_cnt_d;
  logic             seg_first_bad_q, seg_first_bad_d;
  logic             seg_rest_bad_q, seg_rest_bad_d;
  logic [CntW-1:0]  total_q, total_d;
  dnv_pkg::status_e err_q, err_d;
  logic [7:0]       pend_q, pend_d;
  logic             pend_valid_q, pend_valid_d;
  logic [CntW-1:0]  mem_cnt_q, mem_cnt_d;
  logic             mem_first_bad_q, mem_first_bad_d;
  logic             mem_rest_bad_q, mem_rest_bad_d;
  logic [CntW-1:0]  paren_q, paren_d;

  logic [7:0]       c;
  logic             c_letter, c_digit, p_letter, p_digit;
  logic             closed;
  dnv_pkg::status_e seg_err, st;
  logic [CntW:0]    mlen;

  assign c        = beat_i.name_byte;
  assign c_letter = dnv_pkg::is_letter(c);
  assign c_digit  = dnv_pkg::is_digit(c);
  assign p_letter = dnv_pkg::is_letter(pend_q);
  assign p_digit  = dnv_pkg::is_digit(pend_q);
  assign closed   = pend_valid_q && (pend_q == dnv_pkg::CH_RPAR);
  assign seg_err  = dnv_pkg::seg_check(err_q, seg_cnt_q, seg_first_bad_q | seg_rest_bad_q);

  // end-of-name result
  always_comb begin
    st   = dnv_pkg::ST_OK;
    mlen = '0;
    if (phase_q == dnv_pkg::PH_QUAL) begin
      if (total_q == '0 && seg_cnt_q == '0) begin
        st = dnv_pkg::ST_EMPTY;
      end else if (seg_err == dnv_pkg::ST_OK && total_q > dnv_pkg::NameLim) begin
        st = dnv_pkg::ST_NAME_LONG;
      end else begin
        st = seg_err;
      end
    end else begin
      if (err_q != dnv_pkg::ST_OK) st = err_q;
      else if (paren_q > dnv_pkg::NameLim) st = dnv_pkg::ST_NAME_LONG;
      else if (!closed) st = dnv_pkg::ST_STRUCT;
      else if (mem_cnt_q > dnv_pkg::PartLim) st = dnv_pkg::ST_PART_LONG;
      else if (mem_cnt_q == '0) st = dnv_pkg::ST_EMPTY_MEMBER;
      else if (mem_first_bad_q || mem_rest_bad_q) st = dnv_pkg::ST_BAD_CHAR;
      else st = dnv_pkg::ST_OK;
      mlen = {1'b0, mem_cnt_q} + (CntW+1)'(pend_valid_q && !closed);
    end
  end

  assign result_o.status         = st;
  assign result_o.dataset_length = (phase_q == dnv_pkg::PH_QUAL) ? total_q : paren_q;
  assign result_o.member_length  = (mlen > (CntW+1)'(dnv_pkg::MemLenMax)) ?
                                   dnv_pkg::MemLenMax : mlen[dnv_pkg::MemLenW-1:0];
  assign result_o.has_member     = (phase_q == dnv_pkg::PH_MEMBER);

  always_comb begin
    phase_d         = phase_q;
    seg_cnt_d       = seg_cnt_q;
    seg_first_bad_d = seg_first_bad_q;
    seg_rest_bad_d  = seg_rest_bad_q;
    total_d         = total_q;
    err_d           = err_q;
    pend_d          = pend_q;
    pend_valid_d    = pend_valid_q;
    mem_cnt_d       = mem_cnt_q;
    mem_first_bad_d = mem_first_bad_q;
    mem_rest_bad_d  = mem_rest_bad_q;
    paren_d         = paren_q;
    if (fire_i) begin
      if (c == dnv_pkg::CH_NUL) begin
        phase_d         = dnv_pkg::PH_QUAL;
        seg_cnt_d       = '0;
        seg_first_bad_d = 1'b0;
        seg_rest_bad_d  = 1'b0;
        total_d         = '0;
        err_d           = dnv_pkg::ST_OK;
        pend_d          = '0;
        pend_valid_d    = 1'b0;
        mem_cnt_d       = '0;
        mem_first_bad_d = 1'b0;
        mem_rest_bad_d  = 1'b0;
        paren_d         = '0;
      end else begin
        case (phase_q)
          dnv_pkg::PH_QUAL: begin
            if (c == dnv_pkg::CH_DOT || c == dnv_pkg::CH_LPAR) begin
              err_d           = seg_err;
              seg_cnt_d       = '0;
              seg_first_bad_d = 1'b0;
              seg_rest_bad_d  = 1'b0;
              if (c == dnv_pkg::CH_DOT) begin
                total_d = dnv_pkg::sat_inc(total_q);
              end else begin
                paren_d = total_q;
                phase_d = dnv_pkg::PH_MEMBER;
              end
            end else begin
              if (seg_cnt_q == '0) seg_first_bad_d = ~c_letter;
              else if (!c_letter && !c_digit) seg_rest_bad_d = 1'b1;
              seg_cnt_d = dnv_pkg::sat_inc(seg_cnt_q);
              total_d   = dnv_pkg::sat_inc(total_q);
            end
          end
          dnv_pkg::PH_MEMBER: begin
            // held back one beat so a closing paren is not counted
            if (pend_valid_q) begin
              if (mem_cnt_q == '0) mem_first_bad_d = ~p_letter;
              else if (!p_letter && !p_digit) mem_rest_bad_d = 1'b1;
              mem_cnt_d = dnv_pkg::sat_inc(mem_cnt_q);
            end
            pend_d       = c;
            pend_valid_d = 1'b1;
          end
          default: begin
            phase_d = dnv_pkg::PH_QUAL;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= dnv_pkg::PH_QUAL;
      seg_cnt_q       <= '0;
      seg_first_bad_q <= 1'b0;
      seg_rest_bad_q  <= 1'b0;
      total_q         <= '0;
      err_q           <= dnv_pkg::ST_OK;
      pend_q          <= '0;
      pend_valid_q    <= 1'b0;
      mem_cnt_q       <= '0;
      mem_first_bad_q <= 1'b0;
      mem_rest_bad_q  <= 1'b0;
      paren_q         <= '0;
    end else begin
      phase_q         <= phase_d;
      seg_cnt_q       <= seg_cnt_d;
      seg_first_bad_q <= seg_first_bad_d;
      seg_rest_bad_q  <= seg_rest_bad_d;
      total_q         <= total_d;
      err_q           <= err_d;
      pend_q          <= pend_d;
      pend_valid_q    <= pend_valid_d;
      mem_cnt_q       <= mem_cnt_d;
      mem_first_bad_q <= mem_first_bad_d;
      mem_rest_bad_q  <= mem_rest_bad_d;
      paren_q         <= paren_d;
    end
  end

  a_clear_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && c == dnv_pkg::CH_NUL |=>
      phase_q == dnv_pkg::PH_QUAL && total_q == '0 && !pend_valid_q && err_q == dnv_pkg::ST_OK)
    else $error("state not cleared after end of name");

  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && c != dnv_pkg::CH_NUL && err_q != dnv_pkg::ST_OK |=> err_q == $past(err_q))
    else $error("decided error changed");

  a_no_pend_in_qual: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == dnv_pkg::PH_QUAL |-> !pend_valid_q && mem_cnt_q == '0)
    else $error("member state active outside member phase");

  a_no_member_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !result_o.has_member |-> result_o.member_length == '0)
    else $error("member length without member");

endmodule

// File: hw/rtl/dnv_out_stage.sv
module dnv_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  dnv_pkg::result_t result_i,
  input  logic             out_stall_i,
  output logic             free_o,
  output logic             out_valid_o,
  output dnv_pkg::result_t result_o
);

  logic             valid_q, valid_d;
  dnv_pkg::result_t res_q;

  assign free_o      = ~valid_q | ~out_stall_i;
  assign valid_d     = load_i | (valid_q & out_stall_i);
  assign out_valid_o = valid_q;
  assign result_o    = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= result_i;
    end
  end

endmodule

// File: hw/rtl/dataset_name_validator.sv
// Dataset name checker, one name byte per beat, a zero byte ends the name.
// Throughput: 1 beat per cycle; a zero byte waits only while a stalled result is held.
// When the zero byte is taken from the input register, the result of the name is loaded into
// the result register; the zero byte is taken only when that register is free.
// Reset (rst_ni low, asynchronous) empties both registers and clears the
// scan state to the start of a new name.
module dataset_name_validator (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] name_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] status_o,
  output logic [5:0] dataset_length_o,
  output logic [3:0] member_length_o,
  output logic       has_member_o
);

  dnv_pkg::beat_t   beat;
  dnv_pkg::result_t scan_res;
  dnv_pkg::result_t out_res;
  logic             out_free;
  logic             is_end;
  logic             adv;

  assign is_end = (beat.name_byte == dnv_pkg::CH_NUL);
  assign adv    = beat.valid & (~is_end | out_free);

  dnv_in_stage u_in (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .name_byte_i (name_byte_i),
    .adv_i       (adv),
    .in_stall_o  (in_stall_o),
    .beat_o      (beat)
  );

  dnv_scan u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .beat_i   (beat),
    .fire_i   (adv),
    .result_o (scan_res)
  );

  dnv_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (adv & is_end),
    .result_i    (scan_res),
    .out_stall_i (out_stall_i),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .result_o    (out_res)
  );

  assign status_o         = 3'(out_res.status);
  assign dataset_length_o = out_res.dataset_length;
  assign member_length_o  = out_res.member_length;
  assign has_member_o     = out_res.has_member;

endmodule
